@@ design/tpba_pkg.sv @@
// Shared types and constants for the two-point bearing angle block.
// Holds the port payload structs, CORDIC lane state and the arctangent step table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpba_pkg;

	// coordinate and result widths
	localparam int COORD_WIDTH = 24;
	localparam int DW          = COORD_WIDTH + 1;  // difference of two coordinates
	localparam int XW          = COORD_WIDTH + 3;  // cordic x/y, covers gain and sqrt(2)
	localparam int ZW          = 29;               // angle accumulator, 2^-20 degree units
	localparam int ANG_FRAC    = 20;
	localparam int OUT_SHIFT   = 12;
	localparam int OUT_W       = 17;
	localparam int TABLE_LEN   = 24;

	// configuration port
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REF_A_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_A_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_B_X = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REF_B_Y = 8'd3;

	// quadrant codes; on an axis the same code picks 0, 90, 180 or 270 degrees
	localparam logic [1:0] QUAD_1 = 2'd0;
	localparam logic [1:0] QUAD_2 = 2'd1;
	localparam logic [1:0] QUAD_3 = 2'd2;
	localparam logic [1:0] QUAD_4 = 2'd3;

	// angle constants in 2^-20 degree units
	localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * (1 << ANG_FRAC));
	localparam logic [ZW-1:0]        DEG180 = ZW'(180 * (1 << ANG_FRAC));
	localparam logic [ZW-1:0]        DEG360 = ZW'(360 * (1 << ANG_FRAC));

	// axis bearings and full circle in 1/256 degree units
	localparam logic [OUT_W-1:0] BEAR_0    = 17'd0;
	localparam logic [OUT_W-1:0] BEAR_90   = 17'd23040;
	localparam logic [OUT_W-1:0] BEAR_180  = 17'd46080;
	localparam logic [OUT_W-1:0] BEAR_270  = 17'd69120;
	localparam logic [OUT_W-1:0] FULL_OUT  = 17'd92160;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
	} sample_t;

	typedef struct packed {
		logic [OUT_W-1:0] bearing_a;
		logic [OUT_W-1:0] bearing_b;
		logic [OUT_W-1:0] sweep_angle;
	} result_t;

	typedef struct packed {
		logic                  valid;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// one vector on its way through the cordic row
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 axis;
		logic [1:0]           quad;
	} lane_t;

	typedef struct packed {
		logic  valid;
		lane_t a;
		lane_t b;
	} stage_t;

	// atan(2^-i) in 2^-20 degree units, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_step(input int unsigned idx);
		logic signed [ZW-1:0] v;
		unique case (idx)
			0:       v = ZW'(47185920);
			1:       v = ZW'(27855475);
			2:       v = ZW'(14718068);
			3:       v = ZW'(7471121);
			4:       v = ZW'(3750058);
			5:       v = ZW'(1876857);
			6:       v = ZW'(938658);
			7:       v = ZW'(469357);
			8:       v = ZW'(234682);
			9:       v = ZW'(117342);
			10:      v = ZW'(58671);
			11:      v = ZW'(29335);
			12:      v = ZW'(14668);
			13:      v = ZW'(7334);
			14:      v = ZW'(3667);
			15:      v = ZW'(1833);
			16:      v = ZW'(917);
			17:      v = ZW'(458);
			18:      v = ZW'(229);
			19:      v = ZW'(115);
			20:      v = ZW'(57);
			21:      v = ZW'(29);
			22:      v = ZW'(14);
			23:      v = ZW'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ design/two_point_bearing_angles.sv @@
// Top level of the two-point bearing angle block.
// Depends on tpba_pkg, tpba_front, tpba_cell and tpba_back.
//
// Usage:
//   Request channel: a position sample is taken at a rising edge with start high
//   and busy low. busy is high only in the first cycle after reset, so a new
//   request can be issued every cycle.
//   Result channel: done is high for one cycle with bearing_a, bearing_b and
//   sweep_angle on result. A request passes two front-end stages, one CORDIC
//   cell per iteration and two back-end stages before its result is shown.
//   Results leave in request order. The receiver cannot stall; each result is
//   valid for its single strobe cycle only.
//   Throughput is one request per cycle: every cell of the CORDIC row works on a
//   different request, A and B vectors side by side.
//   Configuration: cfg_valid with cfg_index and cfg_data writes one reference
//   coordinate (index 0..3: A.x, A.y, B.x, B.y); cfg_ready is always high and
//   other indexes are dropped. Write only while no request is in flight.
//   Reset clears the reference points to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module two_point_bearing_angles #(
	parameter int ITERATIONS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire tpba_pkg::sample_t                 sample,
	output logic                                   done,
	output tpba_pkg::result_t                      result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tpba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic              busy_q;
	logic              accept;
	tpba_pkg::cfg_wr_t cfg;
	tpba_pkg::stage_t  chain [ITERATIONS+1];

	// not ready in the cycle right after reset release
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign accept    = start && !busy_q;
	assign cfg_ready = 1'b1;
	assign cfg       = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

	// differences and magnitudes
	tpba_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.accept (accept),
		.sample (sample),
		.out    (chain[0])
	);

	// cordic row, one cell per iteration
	for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
		tpba_cell #(
			.STAGE (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.in     (chain[g]),
			.out    (chain[g+1])
		);
	end

	// fold, sweep and output register
	tpba_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (chain[ITERATIONS]),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

@@ design/tpba_front.sv @@
// Front end: reference point registers, vector differences and magnitude/quadrant split.
// Depends on tpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpba_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tpba_pkg::cfg_wr_t cfg,
	input  wire logic              accept,
	input  wire tpba_pkg::sample_t sample,
	output tpba_pkg::stage_t       out
);

	localparam int CW = tpba_pkg::COORD_WIDTH;
	localparam int DW = tpba_pkg::DW;
	localparam int XW = tpba_pkg::XW;

	logic signed [CW-1:0] ref_ax_q, ref_ay_q, ref_bx_q, ref_by_q;

	logic                 vld_s1;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1;

	logic                 vld_s2;
	tpba_pkg::lane_t      a_s2, b_s2;

	// sign-extended difference ref - pos
	function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] r,
			input logic signed [CW-1:0] p);
		return {r[CW-1], r} - {p[CW-1], p};
	endfunction

	// magnitudes, quadrant and axis cases of one vector
	function automatic tpba_pkg::lane_t prep_lane(input logic signed [DW-1:0] dx,
			input logic signed [DW-1:0] dy);
		tpba_pkg::lane_t l;
		logic [DW-1:0]   mx, my;
		logic            x_zero, y_zero, x_neg, y_neg;
		x_zero = (dx == '0);
		y_zero = (dy == '0);
		x_neg  = dx[DW-1];
		y_neg  = dy[DW-1];
		mx     = x_neg ? (~dx + 1'b1) : dx;
		my     = y_neg ? (~dy + 1'b1) : dy;
		l.x    = XW'(mx);
		l.y    = XW'(my);
		l.z    = '0;
		l.axis = x_zero || y_zero;
		if (x_zero) begin
			// zero vector falls in with the negative y axis
			l.quad = (!y_neg && !y_zero) ? tpba_pkg::QUAD_2 : tpba_pkg::QUAD_4;
		end else if (y_zero) begin
			l.quad = x_neg ? tpba_pkg::QUAD_3 : tpba_pkg::QUAD_1;
		end else if (!x_neg && !y_neg) begin
			l.quad = tpba_pkg::QUAD_1;
		end else if (x_neg && !y_neg) begin
			l.quad = tpba_pkg::QUAD_2;
		end else if (x_neg) begin
			l.quad = tpba_pkg::QUAD_3;
		end else begin
			l.quad = tpba_pkg::QUAD_4;
		end
		return l;
	endfunction

	// reference point registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_ax_q <= '0;
			ref_ay_q <= '0;
			ref_bx_q <= '0;
			ref_by_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tpba_pkg::REG_REF_A_X: ref_ax_q <= cfg.data[CW-1:0];
				tpba_pkg::REG_REF_A_Y: ref_ay_q <= cfg.data[CW-1:0];
				tpba_pkg::REG_REF_B_X: ref_bx_q <= cfg.data[CW-1:0];
				tpba_pkg::REG_REF_B_Y: ref_by_q <= cfg.data[CW-1:0];
				default: ;
			endcase
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
		end
	end

	// differences, then magnitudes
	always_ff @(posedge clk) begin
		dax_s1 <= diff(ref_ax_q, sample.pos_x);
		day_s1 <= diff(ref_ay_q, sample.pos_y);
		dbx_s1 <= diff(ref_bx_q, sample.pos_x);
		dby_s1 <= diff(ref_by_q, sample.pos_y);
		a_s2   <= prep_lane(dax_s1, day_s1);
		b_s2   <= prep_lane(dbx_s1, dby_s1);
	end

	assign out = '{valid: vld_s2, a: a_s2, b: b_s2};

endmodule

`default_nettype wire

@@ design/tpba_cell.sv @@
// One CORDIC vectoring cell: a single rotation step for both vectors.
// Depends on tpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpba_cell #(
	parameter int STAGE = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tpba_pkg::stage_t in,
	output tpba_pkg::stage_t      out
);

	localparam logic signed [tpba_pkg::ZW-1:0] ATAN = tpba_pkg::atan_step(STAGE);

	logic            vld_s1;
	tpba_pkg::lane_t a_s1, b_s1;

	// rotate toward the x axis, floor shifts by the stage index
	function automatic tpba_pkg::lane_t rotate(input tpba_pkg::lane_t l);
		tpba_pkg::lane_t r;
		logic signed [tpba_pkg::XW-1:0] xs, ys;
		xs = l.x >>> STAGE;
		ys = l.y >>> STAGE;
		r  = l;
		if (!l.y[tpba_pkg::XW-1]) begin
			r.x = l.x + ys;
			r.y = l.y - xs;
			r.z = l.z + ATAN;
		end else begin
			r.x = l.x - ys;
			r.y = l.y + xs;
			r.z = l.z - ATAN;
		end
		return r;
	endfunction

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in.valid;
		end
	end

	// lane state
	always_ff @(posedge clk) begin
		a_s1 <= rotate(in.a);
		b_s1 <= rotate(in.b);
	end

	assign out = '{valid: vld_s1, a: a_s1, b: b_s1};

endmodule

`default_nettype wire

@@ design/tpba_back.sv @@
// Back end: angle clamp, quadrant fold to 1/256 degree, and the A-to-B sweep.
// Depends on tpba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpba_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tpba_pkg::stage_t in,
	output logic                  done,
	output tpba_pkg::result_t     result
);

	localparam int ZW  = tpba_pkg::ZW;
	localparam int OW  = tpba_pkg::OUT_W;
	localparam int SH  = tpba_pkg::OUT_SHIFT;

	logic              vld_s1;
	logic [OW-1:0]     bear_a_s1, bear_b_s1;
	logic              done_s2;
	tpba_pkg::result_t result_s2;

	// bearing of one lane in 1/256 degree
	function automatic logic [OW-1:0] fold(input tpba_pkg::lane_t l);
		logic signed [ZW-1:0] zc;
		logic [ZW-1:0]        zu, full;
		logic [OW-1:0]        b;
		if (l.z < $signed(ZW'(1))) begin
			zc = ZW'(1);
		end else if (l.z > tpba_pkg::DEG90 - $signed(ZW'(1))) begin
			zc = tpba_pkg::DEG90 - $signed(ZW'(1));
		end else begin
			zc = l.z;
		end
		zu = zc;
		case (l.quad)
			tpba_pkg::QUAD_1: full = zu;
			tpba_pkg::QUAD_2: full = tpba_pkg::DEG180 - zu;
			tpba_pkg::QUAD_3: full = tpba_pkg::DEG180 + zu;
			default:          full = tpba_pkg::DEG360 - zu;
		endcase
		if (l.axis) begin
			case (l.quad)
				tpba_pkg::QUAD_1: b = tpba_pkg::BEAR_0;
				tpba_pkg::QUAD_2: b = tpba_pkg::BEAR_90;
				tpba_pkg::QUAD_3: b = tpba_pkg::BEAR_180;
				default:          b = tpba_pkg::BEAR_270;
			endcase
		end else begin
			b = full[SH+OW-1:SH];
		end
		return b;
	endfunction

	// sweep from a to b, a full turn when equal
	function automatic logic [OW-1:0] sweep(input logic [OW-1:0] a, input logic [OW-1:0] b);
		logic [OW-1:0] s;
		if (b > a) begin
			s = b - a;
		end else begin
			s = tpba_pkg::FULL_OUT - (a - b);
		end
		return s;
	endfunction

	// valid and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			vld_s1  <= in.valid;
			done_s2 <= vld_s1;
		end
	end

	// bearings, then output register
	always_ff @(posedge clk) begin
		bear_a_s1             <= fold(in.a);
		bear_b_s1             <= fold(in.b);
		result_s2.bearing_a   <= bear_a_s1;
		result_s2.bearing_b   <= bear_b_s1;
		result_s2.sweep_angle <= sweep(bear_a_s1, bear_b_s1);
	end

	assign done   = done_s2;
	assign result = result_s2;

endmodule

`default_nettype wire
